@@ rtl/core/anc_pkg.sv @@
package anc_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 16;
  localparam int POS_W    = 7;
  localparam int CODE_W   = 4;
  localparam int LIDX_W   = 8;
  localparam int ACT_W    = 2;

  // stream packing
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;

  localparam int OUT_CODE_LSB = 0;
  localparam int OUT_PRED_LSB = OUT_CODE_LSB + CODE_W;
  localparam int OUT_POS_LSB  = OUT_PRED_LSB + SAMPLE_W;
  localparam int OUT_USED_W   = OUT_POS_LSB + POS_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SEED   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DECODE = 2'd3;

  localparam int STEP_TAB_DEPTH = 90;

  localparam logic [STEP_W-1:0] STEP_TAB [STEP_TAB_DEPTH] = '{
    16'd6,     16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,
    16'd13,    16'd14,    16'd16,    16'd17,    16'd19,    16'd21,    16'd23,
    16'd25,    16'd28,    16'd31,    16'd34,    16'd37,    16'd41,    16'd45,
    16'd50,    16'd55,    16'd60,    16'd66,    16'd73,    16'd80,    16'd88,
    16'd97,    16'd107,   16'd118,   16'd130,   16'd143,   16'd157,   16'd173,
    16'd190,   16'd209,   16'd230,   16'd253,   16'd279,   16'd307,   16'd337,
    16'd371,   16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,
    16'd724,   16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,
    16'd1411,  16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,
    16'd2749,  16'd3024,  16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,
    16'd5358,  16'd5894,  16'd6484,  16'd7132,  16'd7845,  16'd8630,  16'd9493,
    16'd10442, 16'd11487, 16'd12635, 16'd13899, 16'd15289, 16'd16818, 16'd18500,
    16'd20350, 16'd22385, 16'd24623, 16'd27086, 16'd29794, 16'd32767
  };

  function automatic logic [STEP_W-1:0] step_lookup(input logic [POS_W-1:0] idx);
    logic [STEP_W-1:0] val;
    if (int'(idx) < STEP_TAB_DEPTH) begin
      val = STEP_TAB[idx];
    end else begin
      val = STEP_TAB[STEP_TAB_DEPTH-1];
    end
    return val;
  endfunction

  // index move per code magnitude
  function automatic logic signed [4:0] adjust_of(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd1;
      3'd5:    adj = 5'sd3;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd9;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

@@ rtl/core/adpcm_nibble_codec_core.sv @@
// 4-bit adpcm codec with per-channel prediction and step-table index
//
// input stream (s_axis): one transaction carries one action on one channel;
//   tuser selects the action (seed, load, encode, decode) and the channel,
//   tdata carries sample, next sample, code and load index
// output stream (m_axis): one transaction per accepted input with the code
//   (encode only, zero otherwise), the new prediction and the new step index
//
// differences, absolute values, table search, division and accumulation run through
// one shared 20-bit add/subtract unit under a small sequencer; the block takes one
// transaction at a time and s_axis_tready_o is low while it works. the sequencer
// passes through: load PREP, DONE; decode PREP, ACC, DONE; encode PREP, ABS, DIV,
//   ACC, DONE; seed PREP, ABS, SEARCH, PICK, DONE, with at most 7 search probes
//   for 90 entries, one binary-search probe of the step table per cycle
// a new input can be taken in the cycle after the result is registered; a finished
// result may sit in the output register while the next item is processed
// if the receiver stalls, the result holds in the output register and the
// sequencer waits in its final state until that register frees up
// reset clears every channel's prediction and index to zero and empties the
// output register
module adpcm_nibble_codec_core #(
  parameter int CHANNELS     = 2,
  parameter int STEP_ENTRIES = 90
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample [15:0], next_sample [31:16], code [35:32], load_index [43:36]
  input  logic [anc_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // action [1:0], channel [2]
  input  logic [anc_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // code_out [3:0], prediction [19:4], step_index [26:20]
  output logic [anc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = anc_pkg::POS_W;
  localparam int SW   = anc_pkg::STEP_W;
  localparam int AW   = 20;  // shared unit width

  localparam logic [PW-1:0] NUM_POS  = PW'(STEP_ENTRIES);
  localparam logic [PW-1:0] LAST_POS = PW'(STEP_ENTRIES - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_ABS    = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_PICK   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_ACC    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // step table limited to the configured depth
  function automatic logic [SW-1:0] step_of(input logic [PW-1:0] idx);
    logic [PW-1:0] cidx;
    cidx = (idx >= NUM_POS) ? LAST_POS : idx;
    return anc_pkg::step_lookup(cidx);
  endfunction

  // control
  logic [2:0]       state_q;
  logic [1:0]       k_q;
  logic             out_valid_q;

  // per-channel state
  logic signed [15:0] pred_mem [CHANNELS];
  logic [PW-1:0]      pos_mem  [CHANNELS];

  // item payload
  logic [1:0]         act_q;
  logic [CH_W-1:0]    ch_q;
  logic signed [15:0] smp_q;
  logic signed [15:0] nxt_q;
  logic [3:0]         nib_q;
  logic [7:0]         lidx_q;

  // working registers
  logic [PW-1:0]        pos_q;
  logic [SW-1:0]        mag_q;
  logic signed [16:0]   nmag_q;
  logic signed [AW-1:0] diff_q;
  logic signed [AW-1:0] acc_q;
  logic [PW-1:0]        lo_q;
  logic [PW-1:0]        hi_q;

  // output register
  logic [3:0]         out_code_q;
  logic signed [15:0] out_pred_q;
  logic [PW-1:0]      out_pos_q;

  logic               s_fire;
  logic [CH_W-1:0]    ch_sel;
  logic               done_go;
  logic [1:0]         bit_sel;
  logic [PW-1:0]      mid;
  logic [SW-1:0]      step_rd;
  logic [SW-1:0]      pick_lo_step;
  logic [SW-1:0]      pick_hi_step;
  logic [16:0]        pair_sum;

  // shared add/subtract unit
  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic                 alu_sub;
  logic signed [AW-1:0] alu_sum;

  logic signed [8:0]  pos_next;
  logic [PW-1:0]      pos_clamped;
  logic signed [15:0] pred_sat;
  logic [3:0]         fin_code;
  logic signed [15:0] fin_pred;
  logic [PW-1:0]      fin_pos;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign done_go         = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // channels beyond the configured count share the last one
  assign ch_sel = (int'(s_axis_tuser_i[2]) >= CHANNELS) ? CH_W'(CHANNELS - 1)
                                                        : CH_W'(s_axis_tuser_i[2]);

  assign bit_sel  = 2'd2 - k_q;
  assign mid      = PW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign step_rd  = step_of(pos_mem[ch_q]);
  assign pick_lo_step = step_of(lo_q - PW'(1));
  assign pick_hi_step = step_of(lo_q);
  assign pair_sum = {1'b0, pick_lo_step} + {1'b0, pick_hi_step};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_PREP: begin
        // seed: next - sample, encode: sample - prediction
        alu_sub = 1'b1;
        if (act_q == anc_pkg::ACT_SEED) begin
          alu_a = {{4{nxt_q[15]}}, nxt_q};
          alu_b = {{4{smp_q[15]}}, smp_q};
        end else begin
          alu_a = {{4{smp_q[15]}}, smp_q};
          alu_b = {{4{pred_mem[ch_q][15]}}, pred_mem[ch_q]};
        end
      end
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = diff_q;
        alu_sub = diff_q[AW-1];
      end
      ST_SEARCH: begin
        alu_a   = diff_q;
        alu_b   = {4'b0, step_of(mid)};
        alu_sub = 1'b1;
      end
      ST_PICK: begin
        // lower entry wins when 2*diff <= step[lo-1] + step[lo]
        alu_a   = {3'b0, pair_sum};
        alu_b   = {diff_q[AW-2:0], 1'b0};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = diff_q;
        alu_b   = {4'b0, mag_q} << bit_sel;
        alu_sub = 1'b1;
      end
      ST_ACC: begin
        alu_a = acc_q;
        if (nib_q[bit_sel]) begin
          if (nib_q[3]) begin
            alu_b = $signed({{3{nmag_q[16]}}, nmag_q}) >>> k_q;
          end else begin
            alu_b = {4'b0, mag_q} >> k_q;
          end
        end
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(AW-1){1'b0}}, alu_sub};

  // final update of position and prediction
  assign pos_next = $signed({2'b0, pos_q}) + 9'(anc_pkg::adjust_of(nib_q[2:0]));

  always_comb begin
    if (pos_next < 9'sd0) begin
      pos_clamped = '0;
    end else if (pos_next > 9'sd7) begin
      pos_clamped = PW'(7);
    end else begin
      pos_clamped = pos_next[PW-1:0];
    end

    if (acc_q > 20'sd32767) begin
      pred_sat = 16'sh7fff;
    end else if (acc_q < -20'sd32768) begin
      pred_sat = 16'sh8000;
    end else begin
      pred_sat = acc_q[15:0];
    end

    fin_code = '0;
    case (act_q)
      anc_pkg::ACT_SEED: begin
        fin_pred = smp_q;
        fin_pos  = lo_q;
      end
      anc_pkg::ACT_LOAD: begin
        fin_pred = smp_q;
        fin_pos  = (lidx_q > {1'b0, LAST_POS}) ? LAST_POS : lidx_q[PW-1:0];
      end
      anc_pkg::ACT_ENCODE: begin
        fin_code = nib_q;
        fin_pred = pred_sat;
        fin_pos  = pos_clamped;
      end
      default: begin
        fin_pred = pred_sat;
        fin_pos  = pos_clamped;
      end
    endcase
  end

  // sequencer, channel state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pred_mem[i] <= '0;
        pos_mem[i]  <= '0;
      end
    end else begin
      if (m_axis_tready_i && !done_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          k_q <= '0;
          case (act_q)
            anc_pkg::ACT_LOAD:   state_q <= ST_DONE;
            anc_pkg::ACT_DECODE: state_q <= ST_ACC;
            default:             state_q <= ST_ABS;
          endcase
        end
        ST_ABS: begin
          state_q <= (act_q == anc_pkg::ACT_SEED) ? ST_SEARCH : ST_DIV;
        end
        ST_SEARCH: begin
          if (lo_q == hi_q) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          state_q <= ST_DONE;
        end
        ST_DIV: begin
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= ST_ACC;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_ACC: begin
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= ST_DONE;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            pred_mem[ch_q] <= fin_pred;
            pos_mem[ch_q]  <= fin_pos;
            out_valid_q    <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          act_q  <= s_axis_tuser_i[1:0];
          ch_q   <= ch_sel;
          smp_q  <= s_axis_tdata_i[15:0];
          nxt_q  <= s_axis_tdata_i[31:16];
          nib_q  <= s_axis_tdata_i[35:32];
          lidx_q <= s_axis_tdata_i[43:36];
        end
      end
      ST_PREP: begin
        diff_q <= alu_sum;
        pos_q  <= pos_mem[ch_q];
        acc_q  <= {{4{pred_mem[ch_q][15]}}, pred_mem[ch_q]};
        mag_q  <= step_rd;
        nmag_q <= -$signed({1'b0, step_rd});
        lo_q   <= '0;
        hi_q   <= NUM_POS;
        if (act_q == anc_pkg::ACT_ENCODE) begin
          nib_q <= '0;
        end
      end
      ST_ABS: begin
        if (act_q == anc_pkg::ACT_ENCODE) begin
          // remainder starts at 4*|d|, sign goes to the code
          diff_q   <= {alu_sum[AW-3:0], 2'b00};
          nib_q[3] <= diff_q[AW-1];
        end else begin
          diff_q <= alu_sum;
        end
      end
      ST_SEARCH: begin
        if (lo_q != hi_q) begin
          // step[mid] < |d| when the difference is strictly positive
          if (!alu_sum[AW-1] && (alu_sum != '0)) begin
            lo_q <= mid + PW'(1);
          end else begin
            hi_q <= mid;
          end
        end
      end
      ST_PICK: begin
        if (lo_q == '0) begin
          lo_q <= '0;
        end else if (lo_q >= NUM_POS) begin
          lo_q <= LAST_POS;
        end else if (!alu_sum[AW-1]) begin
          lo_q <= lo_q - PW'(1);
        end
      end
      ST_DIV: begin
        if (!alu_sum[AW-1]) begin
          diff_q         <= alu_sum;
          nib_q[bit_sel] <= 1'b1;
        end
      end
      ST_ACC: begin
        acc_q <= alu_sum;
      end
      ST_DONE: begin
        if (done_go) begin
          out_code_q <= fin_code;
          out_pred_q <= fin_pred;
          out_pos_q  <= fin_pos;
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(anc_pkg::OUT_TDATA_W - anc_pkg::OUT_USED_W)'(0),
                            out_pos_q, out_pred_q, out_code_q};

endmodule

@@ rtl/core/anc_chk.sv @@
module anc_chk #(
  parameter int STEP_ENTRIES = 90
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_i,
  input logic                            m_axis_tvalid_i,
  input logic                            m_axis_tready_i,
  input logic [anc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);

  localparam int PW = anc_pkg::POS_W;
  localparam logic [PW-1:0] LAST_POS = PW'(STEP_ENTRIES - 1);

  logic [PW-1:0]              out_pos;
  logic [anc_pkg::CODE_W-1:0] out_code;

  assign out_pos  = m_axis_tdata_i[anc_pkg::OUT_POS_LSB +: anc_pkg::POS_W];
  assign out_code = m_axis_tdata_i[anc_pkg::OUT_CODE_LSB +: anc_pkg::CODE_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // one item at a time: busy after every input transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("input taken while busy");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> out_pos <= LAST_POS)
    else $error("step index beyond table");

  // a nonzero code only comes from encode, whose index is clamped to 0..7
  a_enc_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (out_code != '0) |-> out_pos <= PW'(7))
    else $error("encode index not clamped");

endmodule

bind adpcm_nibble_codec_core anc_chk #(
  .STEP_ENTRIES(STEP_ENTRIES)
) u_anc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
